// ===== hdl/gda_pkg.sv =====
// Shared types, constants and calendar functions for the Gregorian date adder.
// Used by gda_ctrl, gda_dp and gregorian_date_adder. No other dependencies.
package gda_pkg;

    // Widths of the held year and of the usable part of the amount.
    localparam int YEAR_BITS   = 16;
    localparam int AMOUNT_BITS = 12;
    localparam int SUM_BITS    = ((YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS) + 1;

    // Port widths.
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int IN_YEAR_W  = 16;
    localparam int AMOUNT_W   = 12;
    localparam int CHECK_W    = ((YEAR_BITS > IN_YEAR_W) ? YEAR_BITS : IN_YEAR_W) + 1;

    typedef logic [YEAR_BITS-1:0]   t_year;
    typedef logic [AMOUNT_BITS-1:0] t_amt;
    typedef logic [SUM_BITS-1:0]    t_sum;
    typedef logic [DAY_W-1:0]       t_day;
    typedef logic [MONTH_W-1:0]     t_month;

    localparam t_year YEAR_MAX = '1;

    // Operation codes.
    localparam logic [1:0] MODE_SET    = 2'd0;
    localparam logic [1:0] MODE_DAYS   = 2'd1;
    localparam logic [1:0] MODE_MONTHS = 2'd2;
    localparam logic [1:0] MODE_YEARS  = 2'd3;

    // Calendar constants.
    localparam t_month MONTH_JAN       = 4'd1;
    localparam t_month MONTH_FEB       = 4'd2;
    localparam t_month MONTH_APR       = 4'd4;
    localparam t_month MONTH_JUN       = 4'd6;
    localparam t_month MONTH_SEP       = 4'd9;
    localparam t_month MONTH_NOV       = 4'd11;
    localparam t_month MONTH_DEC       = 4'd12;
    localparam t_month MONTHS_PER_YEAR = 4'd12;
    localparam t_day   DAY_FIRST       = 5'd1;
    localparam t_day   DAYS_FEB        = 5'd28;
    localparam t_day   DAYS_FEB_LEAP   = 5'd29;
    localparam t_day   DAYS_30         = 5'd30;
    localparam t_day   DAYS_31         = 5'd31;

    // Divisibility by 25 uses the multiplicative inverse of 25 modulo 2^32:
    // y is a multiple of 25 exactly when y * inverse (mod 2^n) <= (2^n - 1) / 25.
    localparam logic [31:0] INV25_32    = 32'd3264175145;
    localparam t_year       INV25       = INV25_32[YEAR_BITS-1:0];
    localparam t_year       DIV25_LIMIT = t_year'(YEAR_MAX / 25);

    // Division of the month amount by twelve: multiply by a scaled reciprocal,
    // then one correction step.
    localparam int DIV_SHIFT  = 20;
    localparam int RECIP_BITS = DIV_SHIFT - 3;
    localparam int PROD_BITS  = AMOUNT_BITS + RECIP_BITS;
    typedef logic [PROD_BITS-1:0] t_prod;
    localparam logic [RECIP_BITS-1:0] DIV_RECIP = RECIP_BITS'((1 << DIV_SHIFT) / 12);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request payload
        logic set_date;   // check and take the new date
        logic day_step;   // advance one day
        logic div_mul;    // amount times reciprocal of twelve
        logic div_fix;    // quotient and remainder correction
        logic year_q;     // add whole years of a month request
        logic mon_adv;    // advance the month, wrap into the next year
        logic spill;      // move excess days into the following month
        logic year_amt;   // add the amount to the year
        logic publish;    // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;   // no day steps remain
        logic out_free;   // the output register can take a result
    } t_sts;

    function automatic logic leap_year(input t_year y);
        t_year p;
        p = y * INV25;
        return (y[1:0] == 2'b00) && ((p > DIV25_LIMIT) || (y[3:0] == 4'b0000));
    endfunction

    function automatic t_day month_len(input t_month m, input logic lp);
        if (m == MONTH_FEB) begin
            return lp ? DAYS_FEB_LEAP : DAYS_FEB;
        end else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
            return DAYS_30;
        end
        return DAYS_31;
    endfunction

endpackage

// ===== hdl/gda_ctrl.sv =====
// Sequencing state machine of the Gregorian date adder.
// Depends on gda_pkg for the command and status types and the operation codes.
module gda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    input  gda_pkg::t_sts     i_sts,
    output gda_pkg::t_cmd     o_cmd,
    output logic              o_in_stall
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SET    = 4'd1;
    localparam logic [3:0] S_DAYS   = 4'd2;
    localparam logic [3:0] S_MDIV   = 4'd3;
    localparam logic [3:0] S_MREM   = 4'd4;
    localparam logic [3:0] S_MYEAR  = 4'd5;
    localparam logic [3:0] S_MMON   = 4'd6;
    localparam logic [3:0] S_MSPILL = 4'd7;
    localparam logic [3:0] S_YEARS  = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        gda_pkg::MODE_SET:    n_state = S_SET;
                        gda_pkg::MODE_DAYS:   n_state = S_DAYS;
                        gda_pkg::MODE_MONTHS: n_state = S_MDIV;
                        default:              n_state = S_YEARS;
                    endcase
                end
            end
            S_SET: begin
                o_cmd.set_date = 1'b1;
                n_state        = S_FIN;
            end
            S_DAYS: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.day_step = 1'b1;
                end
            end
            S_MDIV: begin
                o_cmd.div_mul = 1'b1;
                n_state       = S_MREM;
            end
            S_MREM: begin
                o_cmd.div_fix = 1'b1;
                n_state       = S_MYEAR;
            end
            S_MYEAR: begin
                o_cmd.year_q = 1'b1;
                n_state      = S_MMON;
            end
            S_MMON: begin
                o_cmd.mon_adv = 1'b1;
                n_state       = S_MSPILL;
            end
            S_MSPILL: begin
                o_cmd.spill = 1'b1;
                n_state     = S_FIN;
            end
            S_YEARS: begin
                o_cmd.year_amt = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/gda_dp.sv =====
// Datapath of the Gregorian date adder: date registers, shared saturating
// year adder, divide-by-twelve unit and the output register. Depends on gda_pkg.
module gda_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gda_pkg::t_cmd            i_cmd,
    output gda_pkg::t_sts            o_sts,
    input  logic [4:0]               i_new_day,
    input  logic [3:0]               i_new_month,
    input  logic [15:0]              i_new_year,
    input  logic [11:0]              i_amount,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [4:0]               o_day_out,
    output logic [3:0]               o_month_out,
    output logic [15:0]              o_year_out,
    output logic                     o_invalid_date,
    output logic                     o_year_overflow
);

    gda_pkg::t_day   r_day,   n_day;
    gda_pkg::t_month r_month, n_month;
    gda_pkg::t_year  r_year,  n_year;
    gda_pkg::t_amt   r_amt,   n_amt;
    gda_pkg::t_day   r_nd,    n_nd;
    gda_pkg::t_month r_nm,    n_nm;
    logic [15:0]     r_ny,    n_ny;
    gda_pkg::t_prod  r_prod,  n_prod;
    gda_pkg::t_amt   r_q,     n_q;
    gda_pkg::t_month r_mon,   n_mon;
    logic            r_bad,   n_bad;
    logic            r_ovf,   n_ovf;
    logic            r_out_valid, n_out_valid;

    gda_pkg::t_sum   year_inc;
    gda_pkg::t_sum   year_sum;
    logic            year_sat;
    gda_pkg::t_year  year_new;
    gda_pkg::t_day   len_cur;
    gda_pkg::t_day   len_set;
    logic            set_ok;
    gda_pkg::t_amt   q0;
    gda_pkg::t_amt   rem0;
    logic [4:0]      msum;

    assign o_sts.cnt_zero = (r_amt == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;

    // One saturating adder serves the year increments of month and year steps.
    always_comb begin
        if (i_cmd.year_q) begin
            year_inc = gda_pkg::t_sum'(r_q);
        end else if (i_cmd.year_amt) begin
            year_inc = gda_pkg::t_sum'(r_amt);
        end else begin
            year_inc = gda_pkg::t_sum'(1);
        end
        year_sum = gda_pkg::t_sum'(r_year) + year_inc;
        year_sat = year_sum > gda_pkg::t_sum'(gda_pkg::YEAR_MAX);
        year_new = year_sat ? gda_pkg::YEAR_MAX : gda_pkg::t_year'(year_sum);
    end

    always_comb begin
        len_cur = gda_pkg::month_len(r_month, gda_pkg::leap_year(r_year));
        len_set = gda_pkg::month_len(r_nm, gda_pkg::leap_year(gda_pkg::t_year'(r_ny)));
        set_ok  = (r_nm >= gda_pkg::MONTH_JAN) && (r_nm <= gda_pkg::MONTH_DEC) &&
                  (r_ny > 16'd1) &&
                  (gda_pkg::CHECK_W'(r_ny) <= gda_pkg::CHECK_W'(gda_pkg::YEAR_MAX)) &&
                  (r_nd >= gda_pkg::DAY_FIRST) && (r_nd <= len_set);
        q0      = gda_pkg::t_amt'(r_prod >> gda_pkg::DIV_SHIFT);
        rem0    = r_amt - gda_pkg::t_amt'(q0 * gda_pkg::t_amt'(gda_pkg::MONTHS_PER_YEAR));
        msum    = 5'(r_month) + 5'(r_mon);
    end

    always_comb begin
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_amt       = r_amt;
        n_nd        = r_nd;
        n_nm        = r_nm;
        n_ny        = r_ny;
        n_prod      = r_prod;
        n_q         = r_q;
        n_mon       = r_mon;
        n_bad       = r_bad;
        n_ovf       = r_ovf;
        n_out_valid = i_cmd.publish | (r_out_valid & i_out_stall);

        if (i_cmd.load) begin
            n_amt = gda_pkg::t_amt'(i_amount);
            n_nd  = i_new_day;
            n_nm  = i_new_month;
            n_ny  = i_new_year;
            n_bad = 1'b0;
            n_ovf = 1'b0;
        end

        if (i_cmd.set_date) begin
            if (set_ok) begin
                n_day   = r_nd;
                n_month = r_nm;
                n_year  = gda_pkg::t_year'(r_ny);
            end else begin
                n_bad = 1'b1;
            end
        end

        if (i_cmd.day_step) begin
            n_amt = r_amt - 1'b1;
            if ((6'(r_day) + 6'd1) > 6'(len_cur)) begin
                n_day = gda_pkg::DAY_FIRST;
                if (r_month >= gda_pkg::MONTH_DEC) begin
                    if (r_year == gda_pkg::YEAR_MAX) begin
                        // Last day of the largest year: hold there and stop.
                        n_day   = gda_pkg::DAYS_31;
                        n_month = gda_pkg::MONTH_DEC;
                        n_ovf   = 1'b1;
                        n_amt   = '0;
                    end else begin
                        n_month = gda_pkg::MONTH_JAN;
                        n_year  = r_year + 1'b1;
                    end
                end else begin
                    n_month = r_month + 1'b1;
                end
            end else begin
                n_day = r_day + 1'b1;
            end
        end

        if (i_cmd.div_mul) begin
            n_prod = gda_pkg::t_prod'(r_amt) * gda_pkg::t_prod'(gda_pkg::DIV_RECIP);
        end

        if (i_cmd.div_fix) begin
            // The scaled reciprocal may leave the quotient one short.
            if (rem0 >= gda_pkg::t_amt'(gda_pkg::MONTHS_PER_YEAR)) begin
                n_q   = q0 + 1'b1;
                n_mon = gda_pkg::t_month'(rem0 - gda_pkg::t_amt'(gda_pkg::MONTHS_PER_YEAR));
            end else begin
                n_q   = q0;
                n_mon = gda_pkg::t_month'(rem0);
            end
            // Twelve months or fewer are added as months, not split into years.
            if (r_amt <= gda_pkg::t_amt'(gda_pkg::MONTHS_PER_YEAR)) begin
                n_q   = '0;
                n_mon = gda_pkg::t_month'(r_amt);
            end
        end

        if (i_cmd.year_q || i_cmd.year_amt) begin
            n_year = year_new;
            n_ovf  = r_ovf | year_sat;
        end

        if (i_cmd.mon_adv) begin
            if (msum > 5'(gda_pkg::MONTHS_PER_YEAR)) begin
                n_month = gda_pkg::t_month'(msum - 5'(gda_pkg::MONTHS_PER_YEAR));
                n_year  = year_new;
                n_ovf   = r_ovf | year_sat;
            end else begin
                n_month = gda_pkg::t_month'(msum);
            end
        end

        if (i_cmd.spill) begin
            if (r_day > len_cur) begin
                n_day   = r_day - len_cur;
                n_month = r_month + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= gda_pkg::DAY_FIRST;
            r_month     <= gda_pkg::MONTH_JAN;
            r_year      <= gda_pkg::t_year'(2000);
            r_out_valid <= 1'b0;
        end else begin
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amt  <= n_amt;
        r_nd   <= n_nd;
        r_nm   <= n_nm;
        r_ny   <= n_ny;
        r_prod <= n_prod;
        r_q    <= n_q;
        r_mon  <= n_mon;
        r_bad  <= n_bad;
        r_ovf  <= n_ovf;
        if (i_cmd.publish) begin
            o_day_out       <= r_day;
            o_month_out     <= r_month;
            o_year_out      <= 16'(r_year);
            o_invalid_date  <= r_bad;
            o_year_overflow <= r_ovf;
        end
    end

endmodule

// ===== hdl/gregorian_date_adder.sv =====
// Top level of the Gregorian date adder: controller, datapath and checks.
// Depends on gda_pkg, gda_ctrl and gda_dp.
//
// Usage: the block holds one date (day, month, year) and takes one request at
// a time on the input channel (i_in_valid / o_in_stall). A request is taken
// at a rising edge with i_in_valid high and o_in_stall low. The mode selects
// set date, add days, add months or add years. Every request returns exactly
// one result on the output channel (o_out_valid / i_out_stall): the date held
// after the operation, a flag for a rejected set and a flag for a year that
// saturated at its maximum.
// From acceptance, a request steps through its controller states up to S_FIN,
// which loads the result into the output register; days are stepped one per
// cycle by the day-step logic. A new request is taken once the controller is
// back in S_IDLE after the result is loaded, so the block does not take a
// new request before it is through with the last one.
// The output register decouples the sides: a request can be taken while the
// previous result still waits. When the receiver stalls, the result holds and
// the next result waits in the datapath until the register is free.
// Reset (synchronous, active low) sets the date to 1 January 2000 and drops
// o_out_valid; no operation is in progress afterwards.
module gregorian_date_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_new_day,
    input  logic [3:0]  i_new_month,
    input  logic [15:0] i_new_year,
    input  logic [11:0] i_amount,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [15:0] o_year_out,
    output logic        o_invalid_date,
    output logic        o_year_overflow
);

    gda_pkg::t_cmd cmd;
    gda_pkg::t_sts sts;

    // The controller sequences one request through its steps.
    gda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the date and performs each step it is told to.
    gda_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_new_day       (i_new_day),
        .i_new_month     (i_new_month),
        .i_new_year      (i_new_year),
        .i_amount        (i_amount),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_day_out       (o_day_out),
        .o_month_out     (o_month_out),
        .o_year_out      (o_year_out),
        .o_invalid_date  (o_invalid_date),
        .o_year_overflow (o_year_overflow)
    );

    // A result is only loaded into a free output register.
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> sts.out_free)
        else $error("result loaded over a waiting result");

    // After a request is taken, the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while the previous one was in progress");

    // A loaded result is presented in the next cycle.
    a_publish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |=> o_out_valid)
        else $error("loaded result not presented");

    // A returned date never has a zero day or month.
    a_date_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_day_out != 5'd0 && o_month_out != 4'd0))
        else $error("returned date has a zero field");

endmodule

// ===== test/date_adder_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Gregorian date adder: watches both channels, keeps its own
// calendar state, predicts each result and compares it field by field.
// Depends on gda_pkg for the operation codes and field types.
module date_adder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_new_day,
    input  logic [3:0]  i_new_month,
    input  logic [15:0] i_new_year,
    input  logic [11:0] i_amount,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [4:0]  i_day_out,
    input  logic [3:0]  i_month_out,
    input  logic [15:0] i_year_out,
    input  logic        i_invalid_date,
    input  logic        i_year_overflow,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int YEAR_TOP = int'(gda_pkg::YEAR_MAX);

    typedef struct packed {
        gda_pkg::t_day   day;
        gda_pkg::t_month month;
        logic [15:0]     year;
        logic            invalid;
        logic            overflow;
    } t_date_result;

    t_date_result expected_dates[$];

    int held_day;
    int held_month;
    int held_year;
    int mismatches = 0;

    function automatic bit is_leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == 2) begin
            return is_leap_year(y) ? 29 : 28;
        end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // Applies one request to the held date and returns the expected result.
    task automatic apply_date_request(input logic [1:0] mode, input int nd, input int nm,
                                      input int ny, input int amt,
                                      output t_date_result res);
        int d;
        int m;
        int y;
        int months;
        int steps;
        logic bad;
        logic ovf;
        d = held_day;
        m = held_month;
        y = held_year;
        bad = 1'b0;
        ovf = 1'b0;
        case (mode)
            gda_pkg::MODE_SET: begin
                if (nm >= 1 && nm <= 12 && ny > 1 &&
                    nd >= 1 && nd <= days_in_month(nm, ny)) begin
                    d = nd;
                    m = nm;
                    y = ny;
                end else begin
                    bad = 1'b1;
                end
            end
            gda_pkg::MODE_DAYS: begin
                for (steps = 0; steps < amt && !ovf; steps++) begin
                    if (d + 1 > days_in_month(m, y)) begin
                        if (m >= 12) begin
                            if (y >= YEAR_TOP) begin
                                // Stepping past the last day of the last year pins the date.
                                d = 31;
                                m = 12;
                                y = YEAR_TOP;
                                ovf = 1'b1;
                            end else begin
                                d = 1;
                                m = 1;
                                y = y + 1;
                            end
                        end else begin
                            d = 1;
                            m = m + 1;
                        end
                    end else begin
                        d = d + 1;
                    end
                end
            end
            gda_pkg::MODE_MONTHS: begin
                months = amt;
                if (months > 12) begin
                    y = y + months / 12;
                    months = months % 12;
                end
                if (m + months > 12) begin
                    m = m + months - 12;
                    y = y + 1;
                end else begin
                    m = m + months;
                end
                // Saturation is monotone, so one clamp covers both year bumps.
                if (y > YEAR_TOP) begin
                    y = YEAR_TOP;
                    ovf = 1'b1;
                end
                if (d > days_in_month(m, y)) begin
                    d = d - days_in_month(m, y);
                    m = m + 1;
                end
            end
            default: begin
                y = y + amt;
                if (y > YEAR_TOP) begin
                    y = YEAR_TOP;
                    ovf = 1'b1;
                end
            end
        endcase
        held_day = d;
        held_month = m;
        held_year = y;
        res = '{gda_pkg::t_day'(d), gda_pkg::t_month'(m), 16'(y), bad, ovf};
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin
        t_date_result predicted;
        t_date_result oldest;
        if (!i_rst_n) begin
            held_day = 1;
            held_month = 1;
            held_year = 2000;
            expected_dates.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                apply_date_request(i_mode, int'(i_new_day), int'(i_new_month),
                                   int'(i_new_year), int'(i_amount), predicted);
                expected_dates.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_dates.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request outstanding, got %0d-%0d-%0d",
                             $time, i_year_out, i_month_out, i_day_out);
                end else begin
                    oldest = expected_dates.pop_front();
                    check_field("day_out", int'(oldest.day), int'(i_day_out));
                    check_field("month_out", int'(oldest.month), int'(i_month_out));
                    check_field("year_out", int'(oldest.year), int'(i_year_out));
                    check_field("invalid_date", int'(oldest.invalid), int'(i_invalid_date));
                    check_field("year_overflow", int'(oldest.overflow),
                                int'(i_year_overflow));
                end
            end
        end
        o_pending = expected_dates.size();
        o_fail_count = mismatches;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the date adder testbench: clock, reset, request stimulus and receiver
// stalls. Depends on gda_pkg, gregorian_date_adder and date_adder_checker.
module testbench;

    // Even if every request were a 4095-day step with the slowest receiver,
    // the run would need under 3 ms; this limit leaves a wide margin.
    localparam int RUN_LIMIT_NS = 10_000_000;
    localparam int RANDOM_REQUESTS = 110;
    localparam int HOLD_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;
    logic [11:0] amount;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic        invalid_date;
    logic        year_overflow;
    int          fail_count;
    int          pending;

    // Idle and stall rates follow the traffic phase; the sender advances the
    // phase as it issues requests, and the receiver process reads it.
    int phase;
    int sent;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    bit hold_done;
    int big_days_left;

    gregorian_date_adder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_mode          (mode),
        .i_new_day       (new_day),
        .i_new_month     (new_month),
        .i_new_year      (new_year),
        .i_amount        (amount),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_day_out       (day_out),
        .o_month_out     (month_out),
        .o_year_out      (year_out),
        .o_invalid_date  (invalid_date),
        .o_year_overflow (year_overflow)
    );

    date_adder_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_mode          (mode),
        .i_new_day       (new_day),
        .i_new_month     (new_month),
        .i_new_year      (new_year),
        .i_amount        (amount),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_day_out       (day_out),
        .i_month_out     (month_out),
        .i_year_out      (year_out),
        .i_invalid_date  (invalid_date),
        .i_year_overflow (year_overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Issues one request. Inputs change only at the falling edge, and valid is
    // written once per falling edge, so the block sees a clean value at every
    // rising edge. Once offered, a request and its payload hold until taken.
    // The stall is settled at the falling edge, so a low stall there means the
    // request is taken at the following rising edge.
    task automatic send_request(input logic [1:0] op, input int d, input int m,
                                input int y, input int amt);
        phase = (sent < 60) ? 0 : ((sent < 115) ? 1 : 2);
        sender_idle_pct = (phase == 0) ? 37 : ((phase == 1) ? 55 : 0);
        receiver_stall_pct = (phase == 0) ? 55 : ((phase == 1) ? 37 : 0);
        sent++;
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = op;
        new_day = 5'(d);
        new_month = 4'(m);
        new_year = 16'(y);
        amount = 12'(amt);
        while (in_stall) begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Receiver: random stalls per phase, plus one long hold-off when the
    // last phase begins. During the hold the sender keeps offering requests,
    // so the output register and the datapath fill and the input stalls.
    initial begin
        out_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (phase == 2 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(0, 99) < receiver_stall_pct);
            end
        end
    end

    initial begin
        int pick;
        int sel;
        int y;
        int amt;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = gda_pkg::MODE_SET;
        new_day = '0;
        new_month = '0;
        new_year = '0;
        amount = '0;
        phase = 0;
        sent = 0;
        sender_idle_pct = 37;
        receiver_stall_pct = 55;
        big_days_left = 4;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. An all-zero set is rejected for its month of zero.
        send_request(gda_pkg::MODE_SET, 0, 0, 0, 0);
        // The last day of the largest year: day, month and year steps all saturate.
        send_request(gda_pkg::MODE_SET, 31, 12, 65535, 4095);
        send_request(gda_pkg::MODE_DAYS, 0, 0, 0, 1);
        send_request(gda_pkg::MODE_YEARS, 31, 15, 65535, 4095);
        send_request(gda_pkg::MODE_MONTHS, 0, 0, 0, 4095);
        // Leap day in a century year that is not a multiple of 400, then in
        // one that is, then a year step that leaves 29 February in a common
        // year, which the next day step rolls on to 1 March.
        send_request(gda_pkg::MODE_SET, 29, 2, 1900, 0);
        send_request(gda_pkg::MODE_SET, 29, 2, 2000, 0);
        send_request(gda_pkg::MODE_YEARS, 0, 0, 0, 1);
        send_request(gda_pkg::MODE_DAYS, 0, 0, 0, 1);
        send_request(gda_pkg::MODE_SET, 29, 2, 2100, 0);
        send_request(gda_pkg::MODE_SET, 29, 2, 2004, 0);
        send_request(gda_pkg::MODE_YEARS, 0, 0, 0, 0);
        // Day past the end of a 30-day month, day zero, months out of range
        // and the smallest years around the lower limit.
        send_request(gda_pkg::MODE_SET, 31, 4, 2023, 0);
        send_request(gda_pkg::MODE_SET, 0, 5, 2023, 0);
        send_request(gda_pkg::MODE_SET, 1, 13, 2023, 0);
        send_request(gda_pkg::MODE_SET, 1, 15, 2023, 0);
        send_request(gda_pkg::MODE_SET, 1, 1, 1, 0);
        send_request(gda_pkg::MODE_SET, 1, 1, 2, 0);
        send_request(gda_pkg::MODE_DAYS, 0, 0, 0, 4095);
        // Month steps: excess days spill into the next month, a full twelve
        // wraps into the next year, thirteen takes a whole year out first.
        send_request(gda_pkg::MODE_SET, 31, 1, 2023, 0);
        send_request(gda_pkg::MODE_MONTHS, 0, 0, 0, 1);
        send_request(gda_pkg::MODE_MONTHS, 0, 0, 0, 12);
        send_request(gda_pkg::MODE_MONTHS, 0, 0, 0, 13);
        send_request(gda_pkg::MODE_MONTHS, 0, 0, 0, 0);
        send_request(gda_pkg::MODE_SET, 29, 2, 2024, 0);
        send_request(gda_pkg::MODE_YEARS, 0, 0, 0, 1);
        send_request(gda_pkg::MODE_MONTHS, 0, 0, 0, 0);
        // A long day step that runs into the end of the largest year.
        send_request(gda_pkg::MODE_SET, 25, 12, 65534, 0);
        send_request(gda_pkg::MODE_DAYS, 0, 0, 0, 400);

        // Random part: mostly well-formed dates followed by arithmetic on
        // them, with fully random sets as noise. Unused fields carry junk.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                sel = $urandom_range(0, 3);
                case (sel)
                    0: y = $urandom_range(2, 65535);
                    1: y = $urandom_range(1895, 2105);
                    2: y = $urandom_range(65500, 65535);
                    default: y = $urandom_range(1, 655) * 100;
                endcase
                send_request(gda_pkg::MODE_SET,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31)
                                                         : $urandom_range(1, 28),
                             $urandom_range(1, 12), y, $urandom_range(0, 4095));
            end else if (pick < 27) begin
                send_request(gda_pkg::MODE_SET, $urandom_range(0, 31),
                             $urandom_range(0, 15), $urandom_range(0, 65535),
                             $urandom_range(0, 4095));
            end else if (pick < 57) begin
                // Day steps cost one cycle per day, so only a few are long.
                if (big_days_left > 0 && $urandom_range(0, 29) == 0) begin
                    big_days_left--;
                    amt = $urandom_range(0, 4095);
                end else if ($urandom_range(0, 4) == 0) begin
                    amt = $urandom_range(0, 400);
                end else begin
                    amt = $urandom_range(0, 40);
                end
                send_request(gda_pkg::MODE_DAYS, $urandom_range(0, 31),
                             $urandom_range(0, 15), $urandom_range(0, 65535), amt);
            end else if (pick < 77) begin
                amt = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 30);
                send_request(gda_pkg::MODE_MONTHS, $urandom_range(0, 31),
                             $urandom_range(0, 15), $urandom_range(0, 65535), amt);
            end else begin
                amt = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 3);
                send_request(gda_pkg::MODE_YEARS, $urandom_range(0, 31),
                             $urandom_range(0, 15), $urandom_range(0, 65535), amt);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        // Every request has been taken; wait for its result, then a few more
        // cycles in case the block sends something nobody asked for.
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
